// ===== rtl/rle16_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants shared by the RLE16 pixel decoder.
package rle16_pkg;

  // Field widths
  localparam int unsigned WordW   = 16;
  localparam int unsigned CountW  = 15;
  localparam int unsigned LimitW  = 23;
  localparam int unsigned ColorW  = 8;

  // Mark word decoding
  localparam logic [WordW-1:0]  RepeatMark = 16'h8000;
  localparam logic [CountW-1:0] CountMask  = 15'h7FFF;

  // Input operation codes
  typedef enum logic {
    OP_FEED = 1'b0,
    OP_PULL = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_TAKEN   = 3'd0,
    ST_PIXEL   = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_REFUSED = 3'd3,
    ST_STOPPED = 3'd4
  } status_e;

  // Decoder phase
  typedef enum logic [2:0] {
    PH_MARK     = 3'd0,
    PH_REP_IN   = 3'd1,
    PH_COPY_IN  = 3'd2,
    PH_REP_OUT  = 3'd3,
    PH_COPY_OUT = 3'd4,
    PH_STOP     = 3'd5
  } phase_e;

  // Input item
  typedef struct packed {
    logic             operation;
    logic [WordW-1:0] word;
    logic             last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [2:0]        status;
    logic [WordW-1:0]  pixel_565;
    logic [ColorW-1:0] red;
    logic [ColorW-1:0] green;
    logic [ColorW-1:0] blue;
  } out_item_t;

endpackage

// ===== rtl/rle16_pixel_decoder.sv =====
`timescale 1ns / 1ps
// Run-length decoder from 16-bit compressed words to RGB565/RGB888 pixels.
// The decoder takes one item per clock: a feed item (operation 0) hands it one
// compressed word, a pull item (operation 1) asks for the next decoded pixel,
// and every item yields exactly one result item with a status code. Each item
// is decoded in the cycle it is accepted, with a single result register on the
// output side; the input stays ready while that register is empty or being
// emptied, so a new item is accepted every cycle as long as results are taken.
// A mark whose run would push the reserved pixel total past pixel_limit stops
// the decoder, which then answers every item with the stopped status until
// reset. Write pixel_limit through cfg_we_i/cfg_wdata_i while the decoder is
// idle; it applies at the next mark word.
module rle16_pixel_decoder
  import rle16_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [LimitW-1:0] cfg_wdata_i,
  // input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  // result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  // Decoder state
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] run_left_q, run_left_d;
  logic [WordW-1:0]  held_pixel_q, held_pixel_d;
  logic [LimitW-1:0] pixels_out_q, pixels_out_d;
  logic              end_seen_q, end_seen_d;
  logic [LimitW-1:0] pixel_limit_q;

  // Result register
  logic              out_valid_q;
  out_item_t         out_data_q, out_data_d;

  logic              in_fire;
  logic [CountW-1:0] mark_count;
  logic [LimitW:0]   mark_total;
  logic [CountW-1:0] run_dec;
  status_e           res_status;
  logic              res_pixel;
  logic [WordW-1:0]  res_value;
  phase_e            done_phase;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  assign mark_count = in_data_i.word[CountW-1:0] & CountMask;
  assign mark_total = {1'b0, pixels_out_q} + {{(LimitW+1-CountW){1'b0}}, mark_count};
  assign run_dec    = run_left_q - CountW'(1);

  // Decode one item: next state and result
  always_comb begin
    phase_d      = phase_q;
    run_left_d   = run_left_q;
    held_pixel_d = held_pixel_q;
    pixels_out_d = pixels_out_q;
    end_seen_d   = end_seen_q;
    res_status   = ST_TAKEN;
    res_pixel    = 1'b0;
    res_value    = held_pixel_q;
    done_phase   = end_seen_q ? PH_STOP : PH_MARK;

    if (in_data_i.operation == OP_PULL) begin
      unique case (phase_q)
        PH_REP_OUT, PH_COPY_OUT: begin
          res_status = ST_PIXEL;
          res_pixel  = 1'b1;
          run_left_d = run_dec;
          if (run_dec == '0) begin
            phase_d = done_phase;
          end else if (phase_q == PH_COPY_OUT) begin
            phase_d = PH_COPY_IN;
          end
        end
        PH_MARK, PH_REP_IN, PH_COPY_IN: begin
          res_status = ST_EMPTY;
        end
        default: begin
          phase_d    = PH_STOP;
          res_status = ST_STOPPED;
        end
      endcase
    end else begin
      unique case (phase_q)
        PH_REP_OUT, PH_COPY_OUT: begin
          res_status = ST_REFUSED;
        end
        PH_MARK: begin
          if (mark_total > {1'b0, pixel_limit_q}) begin
            phase_d    = PH_STOP;
            res_status = ST_STOPPED;
          end else begin
            end_seen_d   = end_seen_q | in_data_i.last;
            pixels_out_d = mark_total[LimitW-1:0];
            run_left_d   = mark_count;
            if (in_data_i.word > RepeatMark) begin
              phase_d = PH_REP_IN;
            end else if (mark_count == '0) begin
              phase_d = (end_seen_q | in_data_i.last) ? PH_STOP : PH_MARK;
            end else begin
              phase_d = PH_COPY_IN;
            end
          end
        end
        PH_REP_IN: begin
          end_seen_d   = end_seen_q | in_data_i.last;
          held_pixel_d = in_data_i.word;
          if (run_left_q == '0) begin
            phase_d = (end_seen_q | in_data_i.last) ? PH_STOP : PH_MARK;
          end else begin
            phase_d = PH_REP_OUT;
          end
        end
        PH_COPY_IN: begin
          end_seen_d   = end_seen_q | in_data_i.last;
          held_pixel_d = in_data_i.word;
          phase_d      = PH_COPY_OUT;
        end
        default: begin
          phase_d    = PH_STOP;
          res_status = ST_STOPPED;
        end
      endcase
    end

    // Format the result, widening the pixel to RGB888
    out_data_d.status = res_status;
    if (res_pixel) begin
      out_data_d.pixel_565 = res_value;
      out_data_d.red       = {res_value[15:11], 3'b000};
      out_data_d.green     = {res_value[10:5], 2'b00};
      out_data_d.blue      = {res_value[4:0], 3'b000};
    end else begin
      out_data_d.pixel_565 = '0;
      out_data_d.red       = '0;
      out_data_d.green     = '0;
      out_data_d.blue      = '0;
    end
  end

  // Advance decoder state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_MARK;
      run_left_q   <= '0;
      held_pixel_q <= '0;
      pixels_out_q <= '0;
      end_seen_q   <= 1'b0;
    end else if (in_fire) begin
      phase_q      <= phase_d;
      run_left_q   <= run_left_d;
      held_pixel_q <= held_pixel_d;
      pixels_out_q <= pixels_out_d;
      end_seen_q   <= end_seen_d;
    end
  end

  // Hold the pixel limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_limit_q <= '0;
    end else if (cfg_we_i) begin
      pixel_limit_q <= cfg_wdata_i;
    end
  end

  // Result valid: set on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Once stopped, the decoder stays stopped
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_STOP |=> phase_q == PH_STOP)
    else $error("decoder left the stopped phase");

  // A pending pixel always has a nonzero run behind it
  a_out_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_REP_OUT || phase_q == PH_COPY_OUT) |-> run_left_q != '0)
    else $error("pixel pending with empty run");

  // Reserved pixel count never shrinks
  a_pixels_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> pixels_out_q >= $past(pixels_out_q))
    else $error("reserved pixel count decreased");

  // A word fed while a pixel is pending is refused
  a_refuse_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.operation == OP_FEED &&
     (phase_q == PH_REP_OUT || phase_q == PH_COPY_OUT))
    |=> out_valid_q && out_data_q.status == ST_REFUSED)
    else $error("word not refused while pixel pending");

endmodule
